@@ src/tfb_pkg.sv @@
// Shared types, constants and the CRC-16/XModem byte update for the frame builder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tfb_pkg;

  // CRC-16/XModem: polynomial 0x1021, initial value zero, no reflection.
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

  // Frame header bytes, sent in this order.
  localparam logic [7:0] MAGIC_0 = 8'hDE;
  localparam logic [7:0] MAGIC_1 = 8'hAD;
  localparam logic [7:0] MAGIC_2 = 8'hBE;
  localparam logic [7:0] MAGIC_3 = 8'hEF;

  // Register map.
  localparam int unsigned ADDR_W     = 3;
  localparam logic        REG_LENGTH = 1'b0;
  localparam logic [15:0] LENGTH_RESET = 16'd64;

  // Position of a beat within the output burst of one input byte.
  typedef enum logic [3:0] {
    STEP_MAGIC0,
    STEP_MAGIC1,
    STEP_MAGIC2,
    STEP_MAGIC3,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_DATA,
    STEP_CRC_LO,
    STEP_CRC_HI
  } tfb_step_t;

  // Configuration as seen by the framer.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] length_crc;     // CRC over the two length bytes
  } tfb_cfg_t;

  // Everything the serialiser needs to emit the beats of one input byte.
  typedef struct packed {
    logic        has_header;
    logic        has_trailer;
    logic [15:0] length;
    logic [7:0]  data;
    logic [15:0] crc;
  } tfb_job_t;

  // One byte through the CRC, most significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP_BIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/tfb_cfg.sv @@
// APB-style register block holding the payload length and the CRC of its two bytes.
// Depends on tfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfb_cfg
  import tfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output tfb_cfg_t               cfg
);

  logic [15:0] payload_length;
  logic [15:0] length_crc;
  logic        wr_hit;

  // Register index is the word address; low address bits are ignored.
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH);

  // The CRC of the length bytes is worked out at reset and at each write.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= LENGTH_RESET;
      length_crc     <= crc_feed(crc_feed(CRC_INIT, LENGTH_RESET[7:0]), LENGTH_RESET[15:8]);
    end else if (wr_hit) begin
      payload_length <= pwdata[15:0];
      length_crc     <= crc_feed(crc_feed(CRC_INIT, pwdata[7:0]), pwdata[15:8]);
    end
  end

  // Read back.
  always_comb begin
    prdata = 32'h0000_0000;
    if (paddr[2] == REG_LENGTH) begin
      prdata = {16'h0000, payload_length};
    end
  end

  assign cfg.payload_length = payload_length;
  assign cfg.length_crc     = length_crc;

endmodule

`default_nettype wire

@@ src/tfb_framer.sv @@
// Frame state: payload byte count and running CRC; builds the beat job for each byte.
// Depends on tfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfb_framer
  import tfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tfb_cfg_t  cfg,
  input  wire logic      in_accept,
  input  wire logic [7:0] data_byte,
  output tfb_job_t       job
);

  logic [15:0] byte_position;
  logic [15:0] running_crc;
  logic [15:0] byte_position_next;
  logic [15:0] running_crc_next;
  logic [16:0] limit;
  logic [16:0] count_next;
  logic        first;
  logic        closing;
  logic [15:0] crc_base;
  logic [15:0] crc_after;

  // A zero length stands for a full 65536-byte frame.
  always_comb begin
    first      = (byte_position == 16'h0000);
    limit      = (cfg.payload_length == 16'h0000) ? 17'h10000 : {1'b0, cfg.payload_length};
    count_next = {1'b0, byte_position} + 17'd1;
    closing    = (count_next >= limit);
    crc_base   = first ? cfg.length_crc : running_crc;
    crc_after  = crc_feed(crc_base, data_byte);

    byte_position_next = closing ? 16'h0000 : count_next[15:0];
    running_crc_next   = closing ? CRC_INIT : crc_after;

    job.has_header  = first;
    job.has_trailer = closing;
    job.length      = cfg.payload_length;
    job.data        = data_byte;
    job.crc         = crc_after;
  end

  // State moves only when a byte is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'h0000;
      running_crc   <= CRC_INIT;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
    end
  end

endmodule

`default_nettype wire

@@ src/tfb_serializer.sv @@
// Job register and beat sequencer: emits header, length, data and CRC bytes of one job.
// Depends on tfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfb_serializer
  import tfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tfb_job_t job_in,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic      last_of_run,
  output logic      end_of_frame
);

  logic      job_valid;
  tfb_job_t  job;
  tfb_step_t step;
  tfb_step_t last_step;
  logic      beat_done;
  logic      job_done;
  logic      load;

  // Last beat of the held job.
  assign last_step = job.has_trailer ? STEP_CRC_HI : STEP_DATA;

  assign out_valid    = job_valid;
  assign last_of_run  = (step == last_step);
  assign end_of_frame = (step == STEP_CRC_HI);
  assign beat_done    = job_valid && out_ready;
  assign job_done     = beat_done && last_of_run;
  assign in_ready     = !job_valid || job_done;
  assign load         = in_valid && in_ready;

  // Byte selection for the current beat.
  always_comb begin
    case (step)
      STEP_MAGIC0: out_byte = MAGIC_0;
      STEP_MAGIC1: out_byte = MAGIC_1;
      STEP_MAGIC2: out_byte = MAGIC_2;
      STEP_MAGIC3: out_byte = MAGIC_3;
      STEP_LEN_LO: out_byte = job.length[7:0];
      STEP_LEN_HI: out_byte = job.length[15:8];
      STEP_DATA:   out_byte = job.data;
      STEP_CRC_LO: out_byte = job.crc[7:0];
      STEP_CRC_HI: out_byte = job.crc[15:8];
      default:     out_byte = 8'h00;
    endcase
  end

  // Control: a new job may load in the cycle the last beat of the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      step      <= STEP_DATA;
    end else if (load) begin
      job_valid <= 1'b1;
      step      <= job_in.has_header ? STEP_MAGIC0 : STEP_DATA;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (beat_done) begin
      step <= tfb_step_t'(step + 4'd1);
    end
  end

  // Payload of the held job.
  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

`ifndef SYNTH
  // The closing CRC byte is always the final beat of its job.
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    job_valid && end_of_frame |-> last_of_run)
    else $error("end of frame on a beat that is not the last of its job");

  // A job without a header never emits header or length beats.
  a_no_header_skip: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.has_header |-> step >= STEP_DATA)
    else $error("header beat emitted for a middle byte");

  // A job without a trailer ends on its data beat.
  a_no_trailer_stop: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job.has_trailer |-> step <= STEP_DATA)
    else $error("CRC beat emitted for a byte that does not close a frame");

  // A stalled beat keeps its place in the burst.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    job_valid && !out_ready |=> job_valid && $stable(step))
    else $error("beat position moved while the output was stalled");
`endif

endmodule

`default_nettype wire

@@ src/telemetry_frame_builder_crc16_core.sv @@
// Top level of the telemetry frame builder with CRC-16/XModem trailer.
// Depends on tfb_pkg, tfb_cfg, tfb_framer and tfb_serializer.
//
//   channel   | direction | handshake          | content
//   ----------+-----------+--------------------+----------------------------------------
//   s_*       | in        | s_tvalid/s_tready  | payload byte
//   m_*       | out       | m_tvalid/m_tready  | frame byte, last-of-run flag, end of frame
//   APB       | in        | psel/penable       | payload_length register at address 0
//
// A middle payload byte gives one output beat; the first byte of a frame gives seven,
// the last gives three, and a one-byte frame gives nine. The output port moves one beat
// per cycle while m_tready is high. The first beat of a byte appears on the output in
// the cycle after the byte is taken. Reset is synchronous and needs no clearing pass.
// A stalled output holds the current beat and the next input byte waits in the stream
// source until the last beat of the current one leaves.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_builder_crc16_core
  import tfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Input stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
  // Output stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // [7:0] out_byte
  output logic                   m_tlast,   // end_of_frame
  output logic                   m_tuser,   // [0] last_of_run
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  tfb_cfg_t cfg;
  tfb_job_t job;
  logic     in_accept;

  assign in_accept = s_tvalid && s_tready;

  // Register block.
  tfb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame counter and running CRC.
  tfb_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_accept (in_accept),
    .data_byte (s_tdata),
    .job       (job)
  );

  // Output beat sequencer.
  tfb_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .job_in       (job),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .last_of_run  (m_tuser),
    .end_of_frame (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tfb_frame_checker.sv @@
`timescale 1ns / 1ps
// Checker for the telemetry frame builder. It follows the payload stream and the register
// port, works out every frame beat due and compares the output stream beat by beat.
// Depends on tfb_pkg for the register map, the header bytes and the CRC constants.

module tfb_frame_checker
  import tfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,   // [7:0] out_byte
  input  logic              m_tlast,   // end_of_frame
  input  logic              m_tuser,   // [0] last_of_run
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                beats_pending,
  output int                mismatch_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } frame_beat_t;

  // Beats still owed by the block, oldest first, and the framer state as we see it.
  frame_beat_t frame_beats_due[$];
  logic [15:0] frame_length;
  logic [15:0] bytes_taken;
  logic [15:0] crc_so_far;

  // CRC-16/XModem, one message bit at a time, most significant bit first.
  function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] r;
    logic        feedback;
    int          i;
    r = crc;
    for (i = 7; i >= 0; i--) begin
      feedback = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (feedback) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Works out the beats one payload byte causes and queues them.
  task automatic frame_one_byte(input logic [7:0] b);
    frame_beat_t burst [9];
    int          n;
    int          i;
    logic [16:0] count_after;
    logic [16:0] frame_limit;
    n = 0;
    // The first byte of a frame brings the header and the length, low byte first.
    if (bytes_taken == 16'd0) begin
      burst[0] = {MAGIC_0, 1'b0, 1'b0};
      burst[1] = {MAGIC_1, 1'b0, 1'b0};
      burst[2] = {MAGIC_2, 1'b0, 1'b0};
      burst[3] = {MAGIC_3, 1'b0, 1'b0};
      burst[4] = {frame_length[7:0], 1'b0, 1'b0};
      burst[5] = {frame_length[15:8], 1'b0, 1'b0};
      n = 6;
      crc_so_far = crc16_xmodem_step(crc16_xmodem_step(CRC_INIT, frame_length[7:0]),
                                     frame_length[15:8]);
    end
    burst[n] = {b, 1'b0, 1'b0};
    n = n + 1;
    crc_so_far = crc16_xmodem_step(crc_so_far, b);
    // A length of zero stands for 65536 bytes; a byte that reaches or passes the length ends it.
    count_after = {1'b0, bytes_taken} + 17'd1;
    frame_limit = (frame_length == 16'd0) ? 17'h10000 : {1'b0, frame_length};
    if (count_after >= frame_limit) begin
      burst[n]     = {crc_so_far[7:0], 1'b0, 1'b0};
      burst[n + 1] = {crc_so_far[15:8], 1'b0, 1'b1};
      n = n + 2;
      bytes_taken = 16'd0;
      crc_so_far  = CRC_INIT;
    end else begin
      bytes_taken = count_after[15:0];
    end
    burst[n - 1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) begin
      frame_beats_due.push_back(burst[i]);
    end
  endtask

  // Everything is sampled at the rising edge; output beats belong to earlier input bytes,
  // so they are checked before the byte taken at the same edge is predicted.
  always @(posedge clk) begin : watch
    frame_beat_t got;
    frame_beat_t want;
    if (rst) begin
      frame_beats_due.delete();
      frame_length = LENGTH_RESET;
      bytes_taken  = 16'd0;
      crc_so_far   = CRC_INIT;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser, m_tlast};
        if (frame_beats_due.size() == 0) begin
          report_failure($sformatf("beat with none due: byte %02h last_of_run %b end_of_frame %b",
                                   got.out_byte, got.last_of_run, got.end_of_frame));
        end else begin
          want = frame_beats_due.pop_front();
          if (got !== want) begin
            report_failure($sformatf({"beat mismatch: expected byte %02h last_of_run %b ",
                                      "end_of_frame %b, got byte %02h last_of_run %b ",
                                      "end_of_frame %b"},
                                     want.out_byte, want.last_of_run, want.end_of_frame,
                                     got.out_byte, got.last_of_run, got.end_of_frame));
          end
        end
      end
      // Register reads return the length; writes past the map are ignored.
      if (psel && penable && pready && (paddr >> 2) == REG_LENGTH) begin
        if (pwrite) begin
          frame_length = pwdata[15:0];
        end else if (prdata[15:0] !== frame_length) begin
          report_failure($sformatf("length read back as %04h, expected %04h",
                                   prdata[15:0], frame_length));
        end
      end
      if (s_tvalid && s_tready) begin
        frame_one_byte(s_tdata);
      end
    end
    beats_pending = frame_beats_due.size();
  end

endmodule

@@ tb/telemetry_frame_builder_crc16_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the frame builder testbench: clock, reset, payload and register stimulus,
// output back-pressure and the verdict. Depends on tfb_pkg, the block and tfb_frame_checker.

module telemetry_frame_builder_crc16_core_tb;
  import tfb_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 3;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int HOLDOFF_BYTES  = 24;
  localparam int RANDOM_PHASES  = 11;

  // Register addresses; the spare one is the first index past the register map.
  localparam logic [ADDR_W-1:0] ADDR_LENGTH = ADDR_W'(4 * REG_LENGTH);
  localparam logic [ADDR_W-1:0] ADDR_SPARE  = ADDR_W'(4 * (REG_LENGTH + 1));

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_mode_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] data_byte
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;   // [7:0] out_byte
  logic              m_tlast;   // end_of_frame
  logic              m_tuser;   // [0] last_of_run
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int beats_pending;
  int mismatch_count;
  int cycle_count    = 0;
  int burst_left     = 0;
  int holdoff_asked  = 0;
  int holdoff_served = 0;

  telemetry_frame_builder_crc16_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tfb_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .beats_pending  (beats_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("telemetry_frame_builder_crc16_core regression: fail");
      $finish;
    end
  end

  // Output back-pressure: a random pattern, drawn anew each time the last one runs out,
  // broken by a long hold-off whenever the stimulus asks for one.
  initial begin : sink_pacing
    sink_mode_t mode;
    int         left;
    int         tick;
    int         period;
    m_tready = 1'b0;
    mode     = SINK_OPEN;
    left     = 0;
    tick     = 0;
    period   = 2;
    forever begin
      @(negedge clk);
      if (holdoff_served != holdoff_asked) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_served = holdoff_served + 1;
      end else begin
        if (left == 0) begin
          mode   = sink_mode_t'($urandom_range(0, 3));
          left   = $urandom_range(10, 80);
          period = $urandom_range(2, 7);
        end
        left = left - 1;
        tick = tick + 1;
        case (mode)
          SINK_OPEN: begin
            m_tready <= 1'b1;
          end
          SINK_COIN: begin
            m_tready <= ($urandom_range(0, 1) == 1);
          end
          SINK_MOSTLY: begin
            m_tready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            m_tready <= ((tick % period) != 0);
          end
        endcase
      end
    end
  end

  // Offers one payload beat and returns at the falling edge after it is taken,
  // leaving tvalid high so that a following beat can go straight out.
  task automatic push_byte(input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Same as push_byte, but in bursts of random length with random gaps between them.
  task automatic paced_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    push_byte(b);
  endtask

  // Stops the payload stream and waits until every beat due has left the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_read(input logic [ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          phase;
    int          k;
    int          n_bytes;
    int          pick;
    logic [15:0] len;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = 32'h0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset length of 64: open a frame and leave it part-filled.
    push_byte(8'h00);
    push_byte(8'hFF);
    settle();
    // A write past the register map is dropped and the length still reads back as 64.
    cfg_write(ADDR_SPARE, 16'd1);
    cfg_read(ADDR_LENGTH);
    push_byte(8'hA5);
    settle();
    // Lowering the length below the bytes already taken closes the frame on the next byte.
    cfg_write(ADDR_LENGTH, 16'd2);
    push_byte(8'h5A);
    settle();
    // One-byte frames: header, byte and trailer from a single input beat.
    cfg_write(ADDR_LENGTH, 16'd1);
    push_byte(8'h01);
    push_byte(8'h80);
    settle();
    // Three-byte frame with first, middle and last bytes.
    cfg_write(ADDR_LENGTH, 16'd3);
    push_byte(8'h7F);
    push_byte(8'hFE);
    push_byte(8'h00);
    settle();
    // Largest length, sent as FF FF, then cut short by a later write.
    cfg_write(ADDR_LENGTH, 16'hFFFF);
    cfg_read(ADDR_LENGTH);
    push_byte(8'h3C);
    push_byte(8'hC3);
    settle();
    cfg_write(ADDR_LENGTH, 16'd3);
    push_byte(8'h99);
    settle();
    // Zero length means 65536 bytes and goes out as 00 00; end it early the same way.
    cfg_write(ADDR_LENGTH, 16'd0);
    cfg_read(ADDR_LENGTH);
    push_byte(8'h55);
    push_byte(8'hAA);
    settle();
    cfg_write(ADDR_LENGTH, 16'd1);
    push_byte(8'h0F);
    settle();
    // Length 256 puts a non-zero high length byte into the CRC.
    cfg_write(ADDR_LENGTH, 16'd256);
    push_byte(8'hF0);
    settle();
    cfg_write(ADDR_LENGTH, 16'd2);
    push_byte(8'h33);
    settle();

    // Random phases: mostly short frames, now and then a huge length that the next
    // phase's write cuts short mid-frame.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      pick = $urandom_range(0, 11);
      if (pick < 6) begin
        len = 16'($urandom_range(1, 6));
      end else if (pick < 8) begin
        len = 16'($urandom_range(7, 40));
      end else if (pick == 8) begin
        len = 16'd1;
      end else if (pick == 9) begin
        len = 16'hFFFF;
      end else if (pick == 10) begin
        len = 16'h0000;
      end else begin
        len = 16'($urandom_range(41, 1000));
      end
      cfg_write(ADDR_LENGTH, len);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(ADDR_SPARE, 16'($urandom()));
      end
      cfg_read(ADDR_LENGTH);
      // Twice the output is held off for a long stretch while payload keeps coming.
      if (phase == 3 || phase == 8) begin
        holdoff_asked = holdoff_asked + 1;
        for (k = 0; k < HOLDOFF_BYTES; k++) begin
          push_byte(8'($urandom()));
        end
      end
      n_bytes = $urandom_range(16, 32);
      for (k = 0; k < n_bytes; k++) begin
        paced_byte(8'($urandom_range(0, 255)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("telemetry_frame_builder_crc16_core regression: pass");
    end else begin
      $display("telemetry_frame_builder_crc16_core regression: fail");
    end
    $finish;
  end

endmodule
